// ----- sv/bbc_pkg.sv -----
package bbc_pkg;

  localparam int unsigned CharWidth = 8;

  localparam logic [CharWidth-1:0] ChParenOpen   = 8'h28;
  localparam logic [CharWidth-1:0] ChParenClose  = 8'h29;
  localparam logic [CharWidth-1:0] ChSquareOpen  = 8'h5B;
  localparam logic [CharWidth-1:0] ChSquareClose = 8'h5D;
  localparam logic [CharWidth-1:0] ChCurlyOpen   = 8'h7B;
  localparam logic [CharWidth-1:0] ChCurlyClose  = 8'h7D;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusMismatch = 2'd1,
    StatusUnclosed = 2'd2,
    StatusOverflow = 2'd3
  } bbc_status_e;

  typedef logic [CharWidth-1:0] bbc_char_t;

  typedef struct packed {
    logic push;
    logic pop;
  } bbc_op_t;

  typedef struct packed {
    logic        valid;
    bbc_status_e status;
  } bbc_res_t;

  // opener that pairs with a closer, zero when not a closer
  function automatic bbc_char_t opener_for(bbc_char_t c);
    bbc_char_t w;
    w = '0;
    case (c)
      ChParenClose:  w = ChParenOpen;
      ChSquareClose: w = ChSquareOpen;
      ChCurlyClose:  w = ChCurlyOpen;
      default:       w = '0;
    endcase
    return w;
  endfunction

endpackage

// ----- sv/bbc_if.sv -----
interface bbc_in_if import bbc_pkg::*; ();
  logic      valid;
  logic      ready;
  bbc_char_t ch;
  logic      last;

  modport source (output valid, output ch, output last, input ready);
  modport sink (input valid, input ch, input last, output ready);
endinterface

interface bbc_out_if import bbc_pkg::*; ();
  logic        valid;
  logic        ready;
  bbc_status_e status;

  modport source (output valid, output status, input ready);
  modport sink (input valid, input status, output ready);
endinterface

// ----- sv/bracket_balance_checker.sv -----
// Bracket balance checker.
// Input channel in_i carries one character (ch) per transfer; last marks the
// final character of a string. Output channel out_o carries one status per
// string: balanced, mismatch or unmatched closer, unclosed openers, overflow.
// Closers ) ] } pop the stack and must meet their opener; any other byte is
// pushed. The first error of a string is kept and later characters of that
// string are ignored. The stack is a row of StackDepth cells that shift
// together on each push or pop, so the top of stack is always in cell 0.
// Throughput: one character per cycle while in_i.ready is high, set by the shift
// of the cell row and the count/error update in the controller.
// The status is registered: it reaches out_o the cycle after the last
// character's transfer, or waits in skid while main holds an untaken one.
// The output has a main register and a skid register: input keeps flowing
// while one status waits; in_i.ready drops only when both hold a status,
// and rises again once out_o.ready takes one.
// Reset clears the stack count, the error and the valid flags of both output
// registers; the cell contents are left as they are and are never read before
// being written.
module bracket_balance_checker import bbc_pkg::*; #(
  parameter int unsigned StackDepth = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bbc_in_if.sink     in_i,
  bbc_out_if.source  out_o
);

  logic        accept;
  bbc_op_t     op;
  bbc_res_t    res;
  bbc_char_t   cell_data [StackDepth];

  logic        main_valid_q, main_valid_d;
  bbc_status_e main_status_q, main_status_d;
  logic        skid_valid_q, skid_valid_d;
  bbc_status_e skid_status_q, skid_status_d;
  logic        take;

  assign in_i.ready = !skid_valid_q;
  assign accept     = in_i.valid && in_i.ready;

  bbc_ctrl #(
    .StackDepth(StackDepth)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .ch_i     (in_i.ch),
    .last_i   (in_i.last),
    .top_i    (cell_data[0]),
    .op_o     (op),
    .res_o    (res)
  );

  for (genvar i = 0; i < StackDepth; i++) begin : g_cell
    bbc_char_t above;
    bbc_char_t below;
    if (i == 0) begin : g_top
      assign above = in_i.ch;
    end else begin : g_mid
      assign above = cell_data[i-1];
    end
    if (i == StackDepth - 1) begin : g_bottom
      assign below = cell_data[i];
    end else begin : g_rest
      assign below = cell_data[i+1];
    end
    bbc_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (op),
      .above_i (above),
      .below_i (below),
      .data_o  (cell_data[i])
    );
  end

  assign take = main_valid_q && out_o.ready;

  always_comb begin
    main_valid_d  = main_valid_q;
    main_status_d = main_status_q;
    skid_valid_d  = skid_valid_q;
    skid_status_d = skid_status_q;
    if (take) begin
      if (skid_valid_q) begin
        main_status_d = skid_status_q;
        skid_valid_d  = 1'b0;
      end else begin
        main_valid_d  = res.valid;
        main_status_d = res.status;
      end
    end else if (!main_valid_q) begin
      main_valid_d  = res.valid;
      main_status_d = res.status;
    end else if (res.valid) begin
      skid_valid_d  = 1'b1;
      skid_status_d = res.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_status_q <= main_status_d;
    skid_status_q <= skid_status_d;
  end

  assign out_o.valid  = main_valid_q;
  assign out_o.status = main_status_q;

endmodule

// ----- sv/bbc_cell.sv -----
module bbc_cell import bbc_pkg::*; (
  input  logic      clk_i,
  input  bbc_op_t   op_i,
  input  bbc_char_t above_i,
  input  bbc_char_t below_i,
  output bbc_char_t data_o
);

  bbc_char_t data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (op_i.push) begin
      data_d = above_i;
    end else if (op_i.pop) begin
      data_d = below_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ----- sv/bbc_ctrl.sv -----
module bbc_ctrl import bbc_pkg::*; #(
  parameter int unsigned StackDepth = 128
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  bbc_char_t ch_i,
  input  logic      last_i,
  input  bbc_char_t top_i,
  output bbc_op_t   op_o,
  output bbc_res_t  res_o
);

  localparam int unsigned CountWidth = $clog2(StackDepth + 1);
  localparam logic [CountWidth-1:0] CountFull = CountWidth'(StackDepth);

  logic [CountWidth-1:0] count_q, count_d;
  bbc_status_e           err_q, err_d;
  bbc_char_t             want;
  logic [CountWidth-1:0] count_n;
  bbc_status_e           err_n;

  always_comb begin
    want    = opener_for(ch_i);
    count_n = count_q;
    err_n   = err_q;
    op_o    = '0;
    res_o   = '0;
    if (accept_i && (err_q == StatusOk)) begin
      if (want != '0) begin
        if (count_q == '0) begin
          err_n = StatusMismatch;
        end else begin
          op_o.pop = 1'b1;
          count_n  = count_q - 1'b1;
          if (top_i != want) begin
            err_n = StatusMismatch;
          end
        end
      end else begin
        if (count_q == CountFull) begin
          err_n = StatusOverflow;
        end else begin
          op_o.push = 1'b1;
          count_n   = count_q + 1'b1;
        end
      end
    end
    count_d = count_n;
    err_d   = err_n;
    if (accept_i && last_i) begin
      res_o.valid = 1'b1;
      if (err_n != StatusOk) begin
        res_o.status = err_n;
      end else if (count_n != '0) begin
        res_o.status = StatusUnclosed;
      end else begin
        res_o.status = StatusOk;
      end
      count_d = '0;
      err_d   = StatusOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      err_q   <= StatusOk;
    end else begin
      count_q <= count_d;
      err_q   <= err_d;
    end
  end

endmodule

// ----- sv/bbc_checker.sv -----
module bbc_checker import bbc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input bbc_status_e out_status_i
);

  logic in_last_xfer;
  assign in_last_xfer = in_valid_i && in_ready_i && in_last_i;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i))
    else $error("status dropped or changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_last_xfer))
    else $error("status without a final character");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_last_xfer && !out_valid_i |=> out_valid_i)
    else $error("status missing after final character");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no status pending");

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_last_i    (in_i.last),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status)
);

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import bbc_pkg::*;

  localparam int unsigned StackDepth = 128;
  localparam int unsigned RandItems  = 400;
  localparam int unsigned NumDir     = 21;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainWait  = 20;
  localparam int unsigned Limit      = 200000;

  typedef struct {
    bbc_char_t   ch;
    logic        last;
    int unsigned reps;
    logic        typed;
    bbc_status_e want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  bbc_in_if  in_bus ();
  bbc_out_if out_bus ();

  bracket_balance_checker #(
    .StackDepth(StackDepth)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  // predictor state
  bbc_char_t   stack_mem [StackDepth];
  int unsigned stack_fill;
  bbc_status_e string_err;

  bbc_status_e pending_status [$];
  dir_row_t    dir_tab [NumDir];

  int unsigned errors;
  int unsigned cycles;
  int unsigned chars_in;
  int unsigned statuses_seen;
  int unsigned input_stalls;
  int unsigned status_hits [4];
  logic        tx_calm;
  logic        rx_calm;
  logic        hold_done;
  int unsigned hold_left;
  int unsigned rx_stall_left;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("check: mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic bbc_char_t rand_opener();
    case ($urandom_range(0, 2))
      0:       return ChParenOpen;
      1:       return ChSquareOpen;
      default: return ChCurlyOpen;
    endcase
  endfunction

  function automatic bbc_char_t closer_for(bbc_char_t c);
    case (c)
      ChParenOpen:  return ChParenClose;
      ChSquareOpen: return ChSquareClose;
      ChCurlyOpen:  return ChCurlyClose;
      default:      return c;
    endcase
  endfunction

  // one character through the predictor
  task automatic track_char(input bbc_char_t c, input logic lst, output logic has_res,
                            output bbc_status_e st);
    bbc_char_t want;
    logic      closer;
    closer = 1'b1;
    want   = '0;
    case (c)
      ChParenClose:  want = ChParenOpen;
      ChSquareClose: want = ChSquareOpen;
      ChCurlyClose:  want = ChCurlyOpen;
      default:       closer = 1'b0;
    endcase
    if (string_err == StatusOk) begin
      if (closer) begin
        if (stack_fill == 0) begin
          string_err = StatusMismatch;
        end else begin
          stack_fill--;
          if (stack_mem[stack_fill] != want) string_err = StatusMismatch;
        end
      end else if (stack_fill >= StackDepth) begin
        string_err = StatusOverflow;
      end else begin
        stack_mem[stack_fill] = c;
        stack_fill++;
      end
    end
    has_res = lst;
    if (string_err != StatusOk) st = string_err;
    else if (stack_fill != 0) st = StatusUnclosed;
    else st = StatusOk;
    if (lst) begin
      stack_fill = 0;
      string_err = StatusOk;
    end
  endtask

  // called and returns at a falling edge
  task automatic put_char(input bbc_char_t c, input logic lst, input logic typed,
                          input bbc_status_e want);
    int unsigned gap;
    logic        has_res;
    bbc_status_e st;
    gap = tx_calm ? 0 : idle_len();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.ch    <= c;
    in_bus.last  <= lst;
    do @(posedge clk_i); while (!in_bus.ready);
    chars_in++;
    track_char(c, lst, has_res, st);
    if (has_res) pending_status.push_back(typed ? want : st);
    @(negedge clk_i);
  endtask

  // status transfers
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > Limit) begin
      $display("testbench: done, errors");
      $finish;
    end else if (rst_ni) begin
      if (in_bus.valid && !in_bus.ready) input_stalls++;
      if (out_bus.valid && out_bus.ready) begin
        statuses_seen++;
        status_hits[out_bus.status]++;
        if (pending_status.size() == 0) begin
          report_mismatch($sformatf("status %s with none expected", out_bus.status.name()));
        end else begin
          if (out_bus.status != pending_status[0])
            report_mismatch($sformatf("status %s, expected %s", out_bus.status.name(),
                                      pending_status[0].name()));
          void'(pending_status.pop_front());
        end
      end
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    out_bus.ready = 1'b0;
    rx_calm       = 1'b0;
    hold_done     = 1'b0;
    hold_left     = 0;
    rx_stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && statuses_seen >= 30) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
        rx_stall_left = rx_calm ? 0 : idle_len();
      end
    end
  end

  initial begin
    bbc_char_t   str_q [$];
    bbc_char_t   open_q [$];
    bbc_char_t   c;
    int unsigned base;
    int unsigned kind;
    int unsigned pairs;
    int unsigned opened;
    int unsigned depth;
    int unsigned cut;
    int unsigned deep_left;

    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.ch    = '0;
    in_bus.last  = 1'b0;
    errors       = 0;
    cycles       = 0;
    chars_in     = 0;
    statuses_seen = 0;
    input_stalls = 0;
    status_hits  = '{0, 0, 0, 0};
    stack_fill   = 0;
    string_err   = StatusOk;
    tx_calm      = 1'b0;
    deep_left    = 2;

    dir_tab = '{
      '{ChParenOpen,   1'b0, 1,   1'b0, StatusOk},
      '{ChParenClose,  1'b1, 1,   1'b1, StatusOk},
      '{ChParenClose,  1'b1, 1,   1'b1, StatusMismatch},  // closer on empty stack
      '{ChSquareOpen,  1'b0, 1,   1'b0, StatusOk},
      '{ChCurlyClose,  1'b1, 1,   1'b1, StatusMismatch},
      '{ChCurlyOpen,   1'b1, 1,   1'b1, StatusUnclosed},
      '{8'h00,         1'b1, 1,   1'b1, StatusUnclosed},  // nul is pushed
      '{8'hFF,         1'b1, 1,   1'b1, StatusUnclosed},
      '{ChParenOpen,   1'b0, 1,   1'b0, StatusOk},
      '{ChSquareClose, 1'b0, 1,   1'b0, StatusOk},
      '{ChParenOpen,   1'b0, 1,   1'b0, StatusOk},        // ignored after error
      '{ChParenClose,  1'b1, 1,   1'b1, StatusMismatch},
      '{ChCurlyOpen,   1'b0, 1,   1'b0, StatusOk},
      '{ChSquareOpen,  1'b0, 1,   1'b0, StatusOk},
      '{ChParenOpen,   1'b0, 1,   1'b0, StatusOk},
      '{ChParenClose,  1'b0, 1,   1'b0, StatusOk},
      '{ChSquareClose, 1'b0, 1,   1'b0, StatusOk},
      '{ChCurlyClose,  1'b1, 1,   1'b0, StatusOk},
      '{8'h41,         1'b0, StackDepth, 1'b0, StatusOk},  // fill the stack
      '{8'h5A,         1'b0, 1,   1'b0, StatusOk},        // push on full stack
      '{ChParenClose,  1'b1, 1,   1'b1, StatusOverflow}
    };

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < NumDir; r++)
      for (int k = 0; k < dir_tab[r].reps; k++)
        put_char(dir_tab[r].ch, dir_tab[r].last && (k == dir_tab[r].reps - 1),
                 dir_tab[r].typed, dir_tab[r].want);

    base = chars_in;
    while (chars_in < base + RandItems) begin
      str_q.delete();
      open_q.delete();
      if ($urandom_range(0, 7) == 0) tx_calm = !tx_calm;
      kind = $urandom_range(0, 99);
      if (deep_left > 0 && kind < 4) begin
        // deep strings around the stack limit
        deep_left--;
        depth = $urandom_range(StackDepth - 2, StackDepth + 1);
        if ($urandom_range(0, 1)) begin
          repeat (depth) begin
            c = rand_opener();
            open_q.push_back(c);
            str_q.push_back(c);
          end
          while (open_q.size() != 0) str_q.push_back(closer_for(open_q.pop_back()));
        end else begin
          repeat (depth) begin
            do c = bbc_char_t'($urandom_range(0, 255));
            while (c == ChParenClose || c == ChSquareClose || c == ChCurlyClose);
            str_q.push_back(c);
          end
        end
      end else if (kind < 70) begin
        pairs  = $urandom_range(1, 10);
        opened = 0;
        while (opened < pairs || open_q.size() != 0) begin
          if (opened < pairs && (open_q.size() == 0 || $urandom_range(0, 1))) begin
            c = rand_opener();
            open_q.push_back(c);
            str_q.push_back(c);
            opened++;
          end else begin
            str_q.push_back(closer_for(open_q.pop_back()));
          end
        end
        if (kind >= 50 && kind < 58) begin
          cut = $urandom_range(1, str_q.size() - 1);
          repeat (cut) void'(str_q.pop_back());
        end else if (kind >= 58) begin
          str_q[$urandom_range(0, str_q.size() - 1)] = bbc_char_t'($urandom_range(0, 255));
        end
      end else begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 5))
              0:       c = ChParenOpen;
              1:       c = ChParenClose;
              2:       c = ChSquareOpen;
              3:       c = ChSquareClose;
              4:       c = ChCurlyOpen;
              default: c = ChCurlyClose;
            endcase
          end else begin
            c = bbc_char_t'($urandom_range(0, 255));
          end
          str_q.push_back(c);
        end
      end
      foreach (str_q[i]) put_char(str_q[i], i == str_q.size() - 1, 1'b0, StatusOk);
    end

    in_bus.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (pending_status.size() != 0)
      report_mismatch($sformatf("%0d statuses never arrived", pending_status.size()));

    $display("summary: %0d characters sent, %0d statuses checked", chars_in, statuses_seen);
    $display("summary: ok %0d, mismatch %0d, unclosed %0d, overflow %0d, %0d input stall cycles",
             status_hits[StatusOk], status_hits[StatusMismatch], status_hits[StatusUnclosed],
             status_hits[StatusOverflow], input_stalls);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/bbc_pkg.sv
sv/bbc_if.sv
sv/bbc_cell.sv
sv/bbc_ctrl.sv
sv/bracket_balance_checker.sv
sv/bbc_checker.sv
test/testbench.sv
